>>> design/min_window_substring_assert.svh
// Assertion macros shared by the minimum window checker.
`ifndef MIN_WINDOW_SUBSTRING_ASSERT_SVH
`define MIN_WINDOW_SUBSTRING_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define MWS_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset.
`define MWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mws_pkg.sv
// Shared types, constants and helpers for the minimum window substring block.
`default_nettype none

package mws_pkg;

    localparam int TEXT_DEPTH_DEF = 4096;
    localparam int ALPHABET_DEF   = 256;
    localparam int SYMBOL_W       = 8;
    localparam int CNT_W          = 13;

    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SYMBOL_W-1:0] symbol_t;
    typedef logic [11:0]         start_t;
    typedef logic [12:0]         length_t;

    localparam cnt_t COUNT_MAX = '1;

    typedef struct packed {
        logic    action;
        symbol_t symbol;
        logic    last;
    } in_item_t;

    typedef struct packed {
        logic    found;
        start_t  window_start;
        length_t window_length;
        logic    overflow;
    } out_item_t;

    // One entry of the per-symbol table
    typedef struct packed {
        cnt_t demand;
        cnt_t window;
    } tab_entry_t;

    // Access request from the scan sequencer to the symbol table
    typedef struct packed {
        logic       rd_en;
        symbol_t    rd_addr;
        logic       wr_en;
        symbol_t    wr_addr;
        tab_entry_t wr_data;
        logic       clear;
    } tab_req_t;

    function automatic cnt_t sat_inc(cnt_t v);
        return (v == COUNT_MAX) ? v : v + cnt_t'(1);
    endfunction

endpackage

`default_nettype wire

>>> design/mws_chan_if.sv
// Valid/ready channel carrying one transaction payload.
`default_nettype none

interface mws_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> design/min_window_substring.sv
// Minimum window substring finder. Pattern bytes (action 0) add demand for
// their symbol; text bytes (action 1) are stored and scanned with a sliding
// window, and a text byte with last set emits one result transaction (found,
// start, length, overflow) and clears all state, so the pattern is loaded
// again for every job. Items are taken one at a time. A pattern byte passes
// through S_TAB; a text byte passes through S_TAB, then through S_BEST for
// the best-window check once the window covers the pattern, with an S_LTXT
// and S_LTAB step before that for every text byte examined under the left
// edge (each step, and the needed byte where the edge stops), then S_EMIT on
// the last byte to load the result register, staying in S_EMIT while the
// previous result still waits there. Each examined byte is a text read
// followed by a read-modify-write of the symbol table, whose read is
// registered; the left edge passes each text byte at most once.
// Tables are cleared through valid bits, so there is no clearing pass after
// reset or after a job. Text beyond TEXT_DEPTH bytes is dropped and flagged.
`default_nettype none

module min_window_substring #(
    parameter int TEXT_DEPTH = mws_pkg::TEXT_DEPTH_DEF,
    parameter int ALPHABET   = mws_pkg::ALPHABET_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mws_chan_if.sink     in,
    mws_chan_if.source   out
);

    localparam int SymW  = $clog2(ALPHABET);
    localparam int AddrW = $clog2(TEXT_DEPTH);
    localparam int PosW  = AddrW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TAB  = 3'd1;
    localparam logic [2:0] S_LTXT = 3'd2;
    localparam logic [2:0] S_LTAB = 3'd3;
    localparam logic [2:0] S_BEST = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    mws_pkg::in_item_t   in_item;
    mws_pkg::tab_req_t   tab_req;
    mws_pkg::tab_entry_t tab;

    logic [SymW-1:0]  sym_lut [256];
    logic [SymW-1:0]  in_sym;
    logic             in_fire;
    logic             pos_full;

    // Control state
    logic [2:0]        state_reg, state_next;
    logic [PosW-1:0]   pos_reg, pos_next;
    logic [AddrW-1:0]  left_reg, left_next;
    mws_pkg::cnt_t     missing_reg, missing_next;
    logic [AddrW-1:0]  best_start_reg, best_start_next;
    logic [PosW-1:0]   best_len_reg, best_len_next;
    logic              overflow_reg, overflow_next;
    logic              out_valid_reg, out_valid_next;

    // Per-item working registers
    logic              act_reg, act_next;
    logic              last_reg, last_next;
    logic [SymW-1:0]   sym_reg, sym_next;
    logic [AddrW-1:0]  cur_p_reg, cur_p_next;
    logic              cur_need_reg, cur_need_next;
    logic              best_ok_reg, best_ok_next;
    logic [SymW-1:0]   e_reg, e_next;
    mws_pkg::out_item_t out_item_reg, out_item_next;

    // Text store
    logic [SymW-1:0]   text_mem [TEXT_DEPTH];
    logic [SymW-1:0]   txt_rd_data_reg;
    logic              txt_wr_en;
    logic              txt_rd_en;
    logic [AddrW-1:0]  txt_rd_addr;

    logic              miss_dec;
    mws_pkg::cnt_t     missing_new;
    logic [AddrW-1:0]  left_inc;
    logic [PosW-1:0]   cand_len;
    logic              best_found;

    // Reduce each byte to the alphabet through a constant table
    for (genvar g = 0; g < 256; g++)
    begin : g_sym_lut
        localparam logic [SymW-1:0] Code = SymW'(g % ALPHABET);
        assign sym_lut[g] = Code;
    end

    assign in_item  = in.payload;
    assign in_sym   = sym_lut[in_item.symbol];
    assign in.ready = (state_reg == S_IDLE);
    assign in_fire  = in.valid && in.ready;
    assign pos_full = (pos_reg >= PosW'(TEXT_DEPTH));
    assign txt_wr_en = in_fire && in_item.action && !pos_full;

    assign left_inc   = left_reg + AddrW'(1);
    assign cand_len   = PosW'(cur_p_reg) - PosW'(left_reg) + PosW'(1);
    assign best_found = (best_len_reg != '0);

    mws_sym_table #(
        .ALPHABET (ALPHABET)
    ) u_sym_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tab_req),
        .rd_entry (tab)
    );

    // Store text at accept time; read back one byte under the left edge
    always_ff @(posedge clk)
    begin
        if (txt_wr_en)
        begin
            text_mem[pos_reg[AddrW-1:0]] <= in_sym;
        end
        if (txt_rd_en)
        begin
            txt_rd_data_reg <= text_mem[txt_rd_addr];
        end
    end

    // Sequencer: table read-modify-write and left edge advance
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        missing_next    = missing_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        overflow_next   = overflow_reg;
        out_valid_next  = out_valid_reg && !out.ready;
        act_next        = act_reg;
        last_next       = last_reg;
        sym_next        = sym_reg;
        cur_p_next      = cur_p_reg;
        cur_need_next   = cur_need_reg;
        best_ok_next    = best_ok_reg;
        e_next          = e_reg;
        out_item_next   = out_item_reg;
        tab_req         = '0;
        txt_rd_en       = 1'b0;
        txt_rd_addr     = left_reg;
        miss_dec        = 1'b0;
        missing_new     = missing_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the transaction and fetch its symbol entry
                if (in_fire)
                begin
                    act_next        = in_item.action;
                    last_next       = in_item.action && in_item.last;
                    sym_next        = in_sym;
                    cur_p_next      = pos_reg[AddrW-1:0];
                    tab_req.rd_en   = 1'b1;
                    tab_req.rd_addr = mws_pkg::SYMBOL_W'(in_sym);
                    state_next      = S_TAB;
                end
            end

            S_TAB:
            begin
                if (!act_reg)
                begin
                    // Pattern byte: raise demand, maybe raise missing count
                    tab_req.wr_en          = 1'b1;
                    tab_req.wr_addr        = mws_pkg::SYMBOL_W'(sym_reg);
                    tab_req.wr_data.demand = mws_pkg::sat_inc(tab.demand);
                    tab_req.wr_data.window = tab.window;
                    if (tab.window <= tab.demand && missing_reg != mws_pkg::COUNT_MAX)
                    begin
                        missing_next = missing_reg + mws_pkg::cnt_t'(1);
                    end
                    state_next = S_IDLE;
                end
                else if (pos_full)
                begin
                    // Text beyond the buffer: flag and drop
                    overflow_next = 1'b1;
                    state_next    = last_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    // Text byte: count it into the window
                    pos_next = pos_reg + PosW'(1);
                    miss_dec = (tab.window < tab.demand) && (missing_reg != '0)
                               && (missing_reg != mws_pkg::COUNT_MAX);
                    missing_new  = miss_dec ? missing_reg - mws_pkg::cnt_t'(1)
                                            : missing_reg;
                    missing_next = missing_new;
                    tab_req.wr_en          = 1'b1;
                    tab_req.wr_addr        = mws_pkg::SYMBOL_W'(sym_reg);
                    tab_req.wr_data.demand = tab.demand;
                    tab_req.wr_data.window = mws_pkg::sat_inc(tab.window);
                    cur_need_next = (tab.demand != '0);
                    if (missing_new != '0)
                    begin
                        state_next = last_reg ? S_EMIT : S_IDLE;
                    end
                    else if (left_reg != cur_p_reg)
                    begin
                        txt_rd_en   = 1'b1;
                        txt_rd_addr = left_reg;
                        state_next  = S_LTXT;
                    end
                    else
                    begin
                        best_ok_next = (tab.demand != '0);
                        state_next   = S_BEST;
                    end
                end
            end

            S_LTXT:
            begin
                // Fetch the table entry of the byte under the left edge
                e_next          = txt_rd_data_reg;
                tab_req.rd_en   = 1'b1;
                tab_req.rd_addr = mws_pkg::SYMBOL_W'(txt_rd_data_reg);
                state_next      = S_LTAB;
            end

            S_LTAB:
            begin
                if (tab.window <= tab.demand)
                begin
                    // Left byte is needed: stop here
                    best_ok_next = (tab.demand != '0);
                    state_next   = S_BEST;
                end
                else
                begin
                    // Surplus byte: drop it from the window and advance
                    tab_req.wr_en          = 1'b1;
                    tab_req.wr_addr        = mws_pkg::SYMBOL_W'(e_reg);
                    tab_req.wr_data.demand = tab.demand;
                    tab_req.wr_data.window = tab.window - mws_pkg::cnt_t'(1);
                    left_next = left_inc;
                    if (left_inc != cur_p_reg)
                    begin
                        txt_rd_en   = 1'b1;
                        txt_rd_addr = left_inc;
                        state_next  = S_LTXT;
                    end
                    else
                    begin
                        best_ok_next = cur_need_reg;
                        state_next   = S_BEST;
                    end
                end
            end

            S_BEST:
            begin
                // Keep the shortest window; earliest wins a tie
                if (best_ok_reg && (!best_found || cand_len < best_len_reg))
                begin
                    best_len_next   = cand_len;
                    best_start_next = left_reg;
                end
                state_next = last_reg ? S_EMIT : S_IDLE;
            end

            S_EMIT:
            begin
                // Load the result once the output register is free, then clear
                if (!out_valid_reg || out.ready)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.found         = best_found;
                    out_item_next.window_start  = best_found
                                                  ? mws_pkg::start_t'(best_start_reg)
                                                  : '0;
                    out_item_next.window_length = mws_pkg::length_t'(best_len_reg);
                    out_item_next.overflow      = overflow_reg;
                    tab_req.clear   = 1'b1;
                    pos_next        = '0;
                    left_next       = '0;
                    missing_next    = '0;
                    best_start_next = '0;
                    best_len_next   = '0;
                    overflow_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pos_reg        <= '0;
            left_reg       <= '0;
            missing_reg    <= '0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            left_reg       <= left_next;
            missing_reg    <= missing_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            overflow_reg   <= overflow_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        last_reg     <= last_next;
        sym_reg      <= sym_next;
        cur_p_reg    <= cur_p_next;
        cur_need_reg <= cur_need_next;
        best_ok_reg  <= best_ok_next;
        e_reg        <= e_next;
        out_item_reg <= out_item_next;
    end

    assign out.valid   = out_valid_reg;
    assign out.payload = out_item_reg;

endmodule

`default_nettype wire

>>> design/mws_sym_table.sv
// Per-symbol demand and window count table: synchronous RAM with valid bits.
`default_nettype none

module mws_sym_table #(
    parameter int ALPHABET = mws_pkg::ALPHABET_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mws_pkg::tab_req_t   req,
    output mws_pkg::tab_entry_t      rd_entry
);

    localparam int SymW = $clog2(ALPHABET);

    mws_pkg::tab_entry_t entry_mem [ALPHABET];
    mws_pkg::tab_entry_t rd_data_reg;
    logic [ALPHABET-1:0] valid_reg;
    logic [ALPHABET-1:0] valid_next;
    logic                rd_valid_reg;
    logic                rd_valid_next;
    logic [SymW-1:0]     rd_idx;
    logic [SymW-1:0]     wr_idx;

    assign rd_idx = req.rd_addr[SymW-1:0];
    assign wr_idx = req.wr_addr[SymW-1:0];

    // Write back and read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entry_mem[wr_idx] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= entry_mem[rd_idx];
        end
    end

    // Track written entries; drop them all at once on clear
    always_comb
    begin
        valid_next    = valid_reg;
        rd_valid_next = rd_valid_reg;
        if (req.rd_en)
        begin
            rd_valid_next = valid_reg[rd_idx];
        end
        if (req.clear)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // An entry never written since the last clear reads as zero counts
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> design/mws_checker.sv
// Port-level checker for the minimum window substring block, with its bind.
`default_nettype none

`include "min_window_substring_assert.svh"

module mws_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire mws_pkg::out_item_t out_payload
);

    // A stalled result transaction holds
    `MWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "result changed while stalled")

    // Every accepted transaction leaves the block busy in the next cycle
    `MWS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input accepted on consecutive cycles")

    // A new result is loaded only while the block is busy emitting
    `MWS_ASSERT_HOLDS(a_emit_busy, $rose(out_valid), $past(!in_ready), "result appeared while idle")

    // No window means zero start and zero length
    `MWS_ASSERT_HOLDS(a_empty_zero, out_valid && !out_payload.found, out_payload.window_start == '0 && out_payload.window_length == '0, "empty result not zeroed")

endmodule

bind min_window_substring mws_checker u_mws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in.valid),
    .in_ready    (in.ready),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .out_payload (out.payload)
);

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the minimum window substring block.
`timescale 1ns / 100ps

module testbench;

    localparam bit ACT_PATTERN  = 1'b0;
    localparam bit ACT_TEXT     = 1'b1;
    localparam int BUF_DEPTH    = 4096;
    localparam int CNT_SAT      = 8191;
    localparam int RANDOM_ITEMS = 1200;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 600000;

    typedef mws_pkg::symbol_t sym_q_t[$];

    logic clk;
    logic rst_n;

    mws_chan_if #(.payload_t(mws_pkg::in_item_t))  in_ch ();
    mws_chan_if #(.payload_t(mws_pkg::out_item_t)) out_ch ();

    min_window_substring u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    // Predictor state
    int unsigned      need_cnt [0:255];
    int unsigned      seen_cnt [0:255];
    mws_pkg::symbol_t text_buf [0:BUF_DEPTH-1];
    int unsigned      absent_cnt;
    int unsigned      win_lo;
    int unsigned      scan_pos;
    int unsigned      best_lo;
    int unsigned      best_len;
    bit               spill;

    mws_pkg::out_item_t expected_windows[$];

    int  error_count;
    int  sent_items;
    int  results_seen;
    int  cycle_count;
    bit  src_idle;
    bit  sink_idle;
    int  sink_hold_cycles;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Clear every table and register of the predictor
    task automatic clear_window_state();
        for (int i = 0; i < 256; i++)
        begin
            need_cnt[i] = 0;
            seen_cnt[i] = 0;
        end
        absent_cnt = 0;
        win_lo     = 0;
        scan_pos   = 0;
        best_lo    = 0;
        best_len   = 0;
        spill      = 1'b0;
    endtask

    // Advance the predictor by one accepted transaction
    task automatic predict_window(input mws_pkg::in_item_t it);
        int unsigned        c;
        int unsigned        w;
        int unsigned        p;
        int unsigned        span;
        mws_pkg::out_item_t res;
        c = it.symbol;
        if (it.action == ACT_PATTERN)
        begin
            // Add demand; missing grows only if the window lacks copies
            w = need_cnt[c];
            if (w < CNT_SAT)
                need_cnt[c] = w + 1;
            if (seen_cnt[c] <= w && absent_cnt < CNT_SAT)
                absent_cnt++;
        end
        else
        begin
            if (scan_pos >= BUF_DEPTH)
                spill = 1'b1;
            else
            begin
                p = scan_pos;
                text_buf[p] = mws_pkg::symbol_t'(c);
                scan_pos = p + 1;
                w = seen_cnt[c];
                if (w < need_cnt[c] && absent_cnt > 0 && absent_cnt < CNT_SAT)
                    absent_cnt--;
                if (w < CNT_SAT)
                    seen_cnt[c] = w + 1;
                if (absent_cnt == 0)
                begin
                    // Drop surplus and unneeded bytes from the left
                    while (win_lo < p &&
                           seen_cnt[text_buf[win_lo]] > need_cnt[text_buf[win_lo]])
                    begin
                        seen_cnt[text_buf[win_lo]]--;
                        win_lo++;
                    end
                    if (need_cnt[text_buf[win_lo]] > 0)
                    begin
                        span = p - win_lo + 1;
                        if (best_len == 0 || span < best_len)
                        begin
                            best_len = span;
                            best_lo  = win_lo;
                        end
                    end
                end
            end
            if (it.last)
            begin
                res.found         = (best_len != 0);
                res.window_start  = (best_len != 0) ? mws_pkg::start_t'(best_lo) : '0;
                res.window_length = mws_pkg::length_t'(best_len);
                res.overflow      = spill;
                expected_windows.push_back(res);
                clear_window_state();
            end
        end
    endtask

    // Offer one transaction and wait until it is taken
    task automatic send_item(input bit act, input mws_pkg::symbol_t sym, input bit lst);
        mws_pkg::in_item_t it;
        int gap;
        it.action = act;
        it.symbol = sym;
        it.last   = lst;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_window(it);
        sent_items++;
    endtask

    // Send one job: pattern bytes, then text with last on the final byte
    task automatic run_job(input sym_q_t pat, input sym_q_t txt, input bit mix);
        for (int i = 0; i < pat.size(); i++)
            send_item(ACT_PATTERN, pat[i], 1'($urandom_range(0, 1)));
        for (int i = 0; i < txt.size(); i++)
        begin
            send_item(ACT_TEXT, txt[i], i == txt.size() - 1);
            // Slip extra demand in between text bytes
            if (mix && i < txt.size() - 1 && $urandom_range(0, 7) == 0)
                send_item(ACT_PATTERN, txt[$urandom_range(0, i)], 1'($urandom_range(0, 1)));
        end
    endtask

    // Stop offering, then wait for every expected result and a tail
    task automatic wait_results_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Result receiver: random stalls plus an optional long hold
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (sink_hold_cycles > 0)
            begin
                stall_left = sink_hold_cycles - 1;
                sink_hold_cycles = 0;
                out_ch.ready <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_gap();
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    initial
    begin : result_check
        mws_pkg::out_item_t got;
        mws_pkg::out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                results_seen++;
                if (expected_windows.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = expected_windows.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("window_start", want.window_start, got.window_start);
                    check_field("window_length", want.window_length, got.window_length);
                    check_field("overflow", want.overflow, got.overflow);
                end
            end
        end
    end

    // Extreme symbols, both actions and each corner of the scan
    task automatic test_directed();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        // Empty pattern never finds a window
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b1);
        // Last on a pattern byte is ignored; surplus bytes are skipped
        send_item(ACT_PATTERN, 8'hFF, 1'b1);
        send_item(ACT_PATTERN, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b0);
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b1);
        // Pattern byte between text bytes raises the missing count
        send_item(ACT_PATTERN, 8'h41, 1'b0);
        send_item(ACT_TEXT, 8'h41, 1'b0);
        send_item(ACT_PATTERN, 8'h41, 1'b0);
        send_item(ACT_TEXT, 8'h42, 1'b0);
        send_item(ACT_TEXT, 8'h41, 1'b1);
        // Pattern byte already covered by the window
        send_item(ACT_PATTERN, 8'h41, 1'b0);
        send_item(ACT_TEXT, 8'h41, 1'b0);
        send_item(ACT_TEXT, 8'h41, 1'b0);
        send_item(ACT_PATTERN, 8'h41, 1'b1);
        send_item(ACT_TEXT, 8'h42, 1'b1);
        // Pattern symbol absent from the text
        send_item(ACT_PATTERN, 8'h7A, 1'b0);
        send_item(ACT_TEXT, 8'h61, 1'b0);
        send_item(ACT_TEXT, 8'h62, 1'b1);
        wait_results_idle();
    endtask

    // Random jobs over small alphabets, with some noise jobs
    task automatic test_random_jobs();
        sym_q_t           pat;
        sym_q_t           txt;
        mws_pkg::symbol_t letters [0:4];
        int               start_count;
        int               kind;
        int               npick;
        int               tlen;
        start_count = sent_items;
        while (sent_items - start_count < RANDOM_ITEMS)
        begin
            kind      = $urandom_range(0, 99);
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            npick     = $urandom_range(2, 5);
            for (int i = 0; i < 5; i++)
                letters[i] = mws_pkg::symbol_t'($urandom_range(0, 255));
            pat.delete();
            txt.delete();
            if (kind >= 10)
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    pat.push_back(letters[$urandom_range(0, npick - 1)]);
            if (kind < 90)
            begin
                tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 150)
                                                    : $urandom_range(1, 40);
                for (int i = 0; i < tlen; i++)
                    if ($urandom_range(0, 9) == 0)
                        txt.push_back(mws_pkg::symbol_t'($urandom_range(0, 255)));
                    else
                        txt.push_back(letters[$urandom_range(0, npick - 1)]);
            end
            else
            begin
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    pat.push_back(mws_pkg::symbol_t'($urandom_range(0, 255)));
                for (int i = $urandom_range(1, 30); i > 0; i--)
                    txt.push_back(mws_pkg::symbol_t'($urandom_range(0, 255)));
            end
            run_job(pat, txt, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                wait_results_idle();
        end
        wait_results_idle();
    endtask

    // Hold the receiver off while short jobs keep arriving
    task automatic test_backpressure();
        sym_q_t           pat;
        sym_q_t           txt;
        mws_pkg::symbol_t a;
        mws_pkg::symbol_t b;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold_cycles = 300;
        for (int j = 0; j < 8; j++)
        begin
            a = mws_pkg::symbol_t'($urandom_range(0, 255));
            b = mws_pkg::symbol_t'($urandom_range(0, 255));
            pat.delete();
            txt.delete();
            pat.push_back(a);
            txt.push_back(b);
            txt.push_back(a);
            run_job(pat, txt, 1'b0);
        end
        // Sender waits for every result before going on
        wait_results_idle();
    endtask

    // Main sequence
    initial
    begin
        error_count      = 0;
        sent_items       = 0;
        results_seen     = 0;
        src_idle         = 1'b0;
        sink_idle        = 1'b0;
        sink_hold_cycles = 0;
        clear_window_state();
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_jobs();
        test_backpressure();

        $display("Run covered %0d input and %0d result transactions, with directed corners,",
                 sent_items, results_seen);
        $display("random jobs with mixed-in demand, and a long output backpressure hold.");
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
